/* hdl/ils_pkg.sv */
// -----------------------------------------------------------------------------
// Indexed list store package
// Shared sizes, operation codes and the control word handed to the cell row.
// -----------------------------------------------------------------------------
package ils_pkg;

   // Store geometry.
   localparam int CAPACITY  = 64;
   localparam int ELEM_BITS = 32;
   localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);

   // Port field widths.
   localparam int MODE_BITS = 3;
   localparam int POS_BITS  = 7;
   localparam int VAL_BITS  = 32;
   localparam int DATA_BITS = 32;
   localparam int OUT_CNT_BITS = 7;

   // Width used for index and fill comparisons.
   localparam int CMP_BITS = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

   // Operation codes carried in the mode field.
   localparam logic [MODE_BITS-1:0] MODE_READ   = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_INSERT = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_DELETE = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_PREV   = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_EMPTY  = 3'd4;

   // Shift actions for the cell row.
   localparam logic [1:0] SHIFT_HOLD   = 2'd0;
   localparam logic [1:0] SHIFT_INSERT = 2'd1;
   localparam logic [1:0] SHIFT_DELETE = 2'd2;

   typedef logic [ELEM_BITS-1:0] elem_type;

   // Control word broadcast to every cell.
   typedef struct packed {
      logic [1:0]          shift;
      logic [CMP_BITS-1:0] position;
      logic [CMP_BITS-1:0] rd_index;
      elem_type            value;
   } cell_ctrl_type;

endpackage

/* hdl/ils_req_if.sv */
// -----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one operation word.
// -----------------------------------------------------------------------------
interface ils_req_if;
   logic                            valid;
   logic                            ready;
   logic [ils_pkg::MODE_BITS-1:0]   mode;
   logic [ils_pkg::POS_BITS-1:0]    position;
   logic [ils_pkg::VAL_BITS-1:0]    value;

   modport source (output valid, mode, position, value, input ready);
   modport sink   (input valid, mode, position, value, output ready);
endinterface

/* hdl/ils_rsp_if.sv */
// -----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result word.
// -----------------------------------------------------------------------------
interface ils_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ils_pkg::DATA_BITS-1:0]     data;
   logic                              ok;
   logic [ils_pkg::OUT_CNT_BITS-1:0]  count;

   modport source (output valid, data, ok, count, input ready);
   modport sink   (input valid, data, ok, count, output ready);
endinterface

/* hdl/ils_cell.sv */
// -----------------------------------------------------------------------------
// List cell
// Holds one element and takes a neighbour's element when the list shifts.
// -----------------------------------------------------------------------------
module ils_cell (
   input  logic                           clock,
   input  logic [ils_pkg::IDX_BITS-1:0]   cell_index,
   input  ils_pkg::cell_ctrl_type         ctrl,
   input  ils_pkg::elem_type              lower_elem,
   input  ils_pkg::elem_type              upper_elem,
   output ils_pkg::elem_type              elem,
   output ils_pkg::elem_type              rd_tap
);

   ils_pkg::elem_type                 elem_ff;
   ils_pkg::elem_type                 elem_in;
   logic [ils_pkg::CMP_BITS-1:0]      index_ext;

   assign index_ext = ils_pkg::CMP_BITS'(cell_index);

   // Insert moves the tail up and drops the value in; delete pulls it down.
   always_comb begin
      elem_in = elem_ff;
      case (ctrl.shift)
         ils_pkg::SHIFT_INSERT: begin
            if (index_ext > ctrl.position) begin
               elem_in = lower_elem;
            end else if (index_ext == ctrl.position) begin
               elem_in = ctrl.value;
            end
         end
         ils_pkg::SHIFT_DELETE: begin
            if (index_ext >= ctrl.position) begin
               elem_in = upper_elem;
            end
         end
         default: elem_in = elem_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
   end

   assign elem   = elem_ff;
   // Only the addressed cell drives the shared read bus.
   assign rd_tap = (index_ext == ctrl.rd_index) ? elem_ff : '0;

endmodule

/* hdl/indexed_list_store_top.sv */
// -----------------------------------------------------------------------------
// Indexed list store
// Fixed-capacity ordered list kept in a row of cells with a fill count.
//
//   channel  dir  handshake        word
//   req      in   valid/ready      mode, position, value
//   rsp      out  valid/ready      data, ok, count
//
// On an insert or delete the whole cell row shifts at once, and reads
// select through a wired-OR of the cell taps.
// One word is accepted per cycle while the result register is free or being
// emptied; a stalled response holds the request side. Synchronous reset
// clears the fill count and the result valid; cell contents are not reset.
// -----------------------------------------------------------------------------
module indexed_list_store_top (
   input  logic           clock,
   input  logic           reset,
   ils_req_if.sink        req,
   ils_rsp_if.source      rsp
);

   logic [ils_pkg::CNT_BITS-1:0]       fill_ff;
   logic [ils_pkg::CNT_BITS-1:0]       fill_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [ils_pkg::DATA_BITS-1:0]      rsp_data_ff;
   logic [ils_pkg::DATA_BITS-1:0]      rsp_data_in;
   logic                               rsp_ok_ff;
   logic                               rsp_ok_in;
   logic [ils_pkg::OUT_CNT_BITS-1:0]   rsp_count_ff;
   logic [ils_pkg::OUT_CNT_BITS-1:0]   rsp_count_in;

   logic                               accept;
   logic [ils_pkg::CMP_BITS-1:0]       pos_ext;
   logic [ils_pkg::CMP_BITS-1:0]       fill_ext;
   logic                               not_full;
   ils_pkg::cell_ctrl_type             ctrl;
   ils_pkg::elem_type                  elems     [ils_pkg::CAPACITY];
   ils_pkg::elem_type                  lower_arr [ils_pkg::CAPACITY];
   ils_pkg::elem_type                  upper_arr [ils_pkg::CAPACITY];
   ils_pkg::elem_type                  taps      [ils_pkg::CAPACITY];
   ils_pkg::elem_type                  rd_elem;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign pos_ext   = ils_pkg::CMP_BITS'(req.position);
   assign fill_ext  = ils_pkg::CMP_BITS'(fill_ff);
   assign not_full  = fill_ext < ils_pkg::CMP_BITS'(ils_pkg::CAPACITY);

   // Decode the word into a shift action, the new fill and the result flags.
   always_comb begin
      ctrl.shift    = ils_pkg::SHIFT_HOLD;
      ctrl.position = pos_ext;
      ctrl.rd_index = pos_ext;
      ctrl.value    = ils_pkg::ELEM_BITS'(req.value);
      fill_in       = fill_ff;
      rsp_ok_in     = 1'b0;
      rsp_data_in   = '0;
      case (req.mode)
         ils_pkg::MODE_READ: begin
            if (pos_ext < fill_ext) begin
               rsp_ok_in   = 1'b1;
               rsp_data_in = ils_pkg::DATA_BITS'(rd_elem);
            end
         end
         ils_pkg::MODE_INSERT: begin
            if (pos_ext <= fill_ext && not_full) begin
               rsp_ok_in  = 1'b1;
               ctrl.shift = accept ? ils_pkg::SHIFT_INSERT : ils_pkg::SHIFT_HOLD;
               fill_in    = fill_ff + ils_pkg::CNT_BITS'(1);
            end
         end
         ils_pkg::MODE_DELETE: begin
            if (pos_ext < fill_ext) begin
               rsp_ok_in  = 1'b1;
               ctrl.shift = accept ? ils_pkg::SHIFT_DELETE : ils_pkg::SHIFT_HOLD;
               fill_in    = fill_ff - ils_pkg::CNT_BITS'(1);
            end
         end
         ils_pkg::MODE_PREV: begin
            ctrl.rd_index = pos_ext - ils_pkg::CMP_BITS'(1);
            if (pos_ext != '0 && pos_ext < fill_ext) begin
               rsp_ok_in   = 1'b1;
               rsp_data_in = ils_pkg::DATA_BITS'(rd_elem);
            end
         end
         ils_pkg::MODE_EMPTY: begin
            rsp_ok_in = 1'b1;
            fill_in   = '0;
         end
         default: rsp_ok_in = 1'b0;
      endcase
   end

   // Neighbour links; the end cells see zero beyond the row.
   always_comb begin
      for (int i = 0; i < ils_pkg::CAPACITY; i++) begin
         lower_arr[i] = (i == 0) ? '0 : elems[(i == 0) ? 0 : i - 1];
         upper_arr[i] = (i == ils_pkg::CAPACITY - 1) ? '0
                      : elems[(i == ils_pkg::CAPACITY - 1) ? i : i + 1];
      end
   end

   // Row of cells.
   for (genvar g = 0; g < ils_pkg::CAPACITY; g++) begin : g_cell
      ils_cell u_cell (
         .clock      (clock),
         .cell_index (ils_pkg::IDX_BITS'(g)),
         .ctrl       (ctrl),
         .lower_elem (lower_arr[g]),
         .upper_elem (upper_arr[g]),
         .elem       (elems[g]),
         .rd_tap     (taps[g])
      );
   end

   // Read bus: at most one cell drives a non-zero tap.
   always_comb begin
      rd_elem = '0;
      for (int i = 0; i < ils_pkg::CAPACITY; i++) begin
         rd_elem = rd_elem | taps[i];
      end
   end

   assign rsp_count_in = ils_pkg::OUT_CNT_BITS'(fill_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            fill_ff <= fill_in;
         end
      end
   end

   // Result word register.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_ok_ff    <= rsp_ok_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;
   assign rsp.ok    = rsp_ok_ff;
   assign rsp.count = rsp_count_ff;

endmodule
